### src/stack_queue_engine_defines.svh
// Assertion macros shared by the stack/queue engine RTL.
// No dependencies; expects clk and arst_n in the including module's scope.
`ifndef STACK_QUEUE_ENGINE_DEFINES_SVH
`define STACK_QUEUE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SQE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stack_queue_engine check failed");

// next-cycle implication, disabled while in reset
`define SQE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stack_queue_engine check failed");

`endif

### src/sqe_pkg.sv
// Shared types and constants of the stack/queue engine.
// Used by sqe_ctrl, sqe_datapath and stack_queue_engine; no dependencies.
package sqe_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	typedef logic [AW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_PALL = 3'd1,
		OP_PINT = 3'd2,
		OP_POP  = 3'd3,
		OP_SWAP = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_PINT_EMPT = 3'd2,
		ST_POP_EMPT  = 3'd3,
		ST_SWAP_SHRT = 3'd4
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PINT,
		S_SWAP_B,
		S_SWAP_WA,
		S_SWAP_WB,
		S_PALL
	} fsm_t;

	typedef enum logic [1:0] {
		RD_FRONT,
		RD_SECOND,
		RD_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_PUSH,
		WR_SWAP_A,
		WR_SWAP_B
	} wr_sel_t;

	typedef struct packed {
		logic    mem_we;
		wr_sel_t wr_sel;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    push_upd;
		logic    pop_upd;
		logic    walk_clr;
		logic    walk_inc;
		logic    tmp_ld;
		logic    res_ld;
		logic    res_mem;
		stat_t   res_status;
		logic    res_last;
	} cmd_t;

	typedef struct packed {
		logic res_free;
		logic empty;
		logic lt2;
		logic full;
		logic walk_last;
	} sts_t;

endpackage

### src/sqe_ctrl.sv
// Controller state machine of the stack/queue engine.
// Depends on sqe_pkg; drives commands into sqe_datapath.
module sqe_ctrl
	import sqe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  sts_t       sts,
	output cmd_t       cmd
);

	fsm_t state_q, state_d;
	logic accept;

	assign in_stall = !((state_q == S_IDLE) && sts.res_free);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(operation))
						OP_PALL: if (!sts.empty) state_d = S_PALL;
						OP_PINT: if (!sts.empty) state_d = S_PINT;
						OP_SWAP: if (!sts.lt2) state_d = S_SWAP_B;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_PINT:    if (sts.res_free) state_d = S_IDLE;
			S_SWAP_B:  state_d = S_SWAP_WA;
			S_SWAP_WA: state_d = S_SWAP_WB;
			S_SWAP_WB: if (sts.res_free) state_d = S_IDLE;
			S_PALL:    if (sts.res_free && sts.walk_last) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.wr_sel     = WR_PUSH;
		cmd.rd_sel     = RD_FRONT;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(operation))
						OP_PUSH: begin
							cmd.res_ld   = 1'b1;
							cmd.res_last = 1'b1;
							if (sts.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.mem_we   = 1'b1;
								cmd.wr_sel   = WR_PUSH;
								cmd.push_upd = 1'b1;
							end
						end
						OP_PALL: begin
							if (sts.empty) begin
								cmd.res_ld   = 1'b1;
								cmd.res_last = 1'b1;
							end else begin
								cmd.rd_en    = 1'b1;
								cmd.rd_sel   = RD_FRONT;
								cmd.walk_clr = 1'b1;
							end
						end
						OP_PINT: begin
							if (sts.empty) begin
								cmd.res_ld     = 1'b1;
								cmd.res_last   = 1'b1;
								cmd.res_status = ST_PINT_EMPT;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_FRONT;
							end
						end
						OP_POP: begin
							cmd.res_ld   = 1'b1;
							cmd.res_last = 1'b1;
							if (sts.empty) begin
								cmd.res_status = ST_POP_EMPT;
							end else begin
								cmd.pop_upd = 1'b1;
							end
						end
						OP_SWAP: begin
							if (sts.lt2) begin
								cmd.res_ld     = 1'b1;
								cmd.res_last   = 1'b1;
								cmd.res_status = ST_SWAP_SHRT;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_FRONT;
							end
						end
						default: begin
							// undefined codes just complete with a blank item
							cmd.res_ld   = 1'b1;
							cmd.res_last = 1'b1;
						end
					endcase
				end
			end
			S_PINT: begin
				if (sts.res_free) begin
					cmd.res_ld   = 1'b1;
					cmd.res_mem  = 1'b1;
					cmd.res_last = 1'b1;
				end
			end
			S_SWAP_B: begin
				// front value sits in read data; park it and fetch the second
				cmd.tmp_ld = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SECOND;
			end
			S_SWAP_WA: begin
				cmd.mem_we = 1'b1;
				cmd.wr_sel = WR_SWAP_A;
			end
			S_SWAP_WB: begin
				if (sts.res_free) begin
					cmd.mem_we   = 1'b1;
					cmd.wr_sel   = WR_SWAP_B;
					cmd.res_ld   = 1'b1;
					cmd.res_last = 1'b1;
				end
			end
			S_PALL: begin
				if (sts.res_free) begin
					cmd.res_ld   = 1'b1;
					cmd.res_mem  = 1'b1;
					cmd.res_last = sts.walk_last;
					if (!sts.walk_last) begin
						cmd.rd_en    = 1'b1;
						cmd.rd_sel   = RD_NEXT;
						cmd.walk_inc = 1'b1;
					end
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### src/sqe_datapath.sv
// Datapath of the stack/queue engine: value store, pointers, result and output registers.
// Depends on sqe_pkg and stack_queue_engine_defines.svh; commanded by sqe_ctrl.
`include "stack_queue_engine_defines.svh"

module sqe_datapath
	import sqe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [31:0] push_value,
	input  logic               cfg_we,
	input  logic               cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               has_value,
	output logic [2:0]         status,
	output logic               last
);

	localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

	logic [31:0]        mem_q [DEPTH];
	logic signed [31:0] rd_data_q;
	logic signed [31:0] tmp_q;
	idx_t               front_q;
	cnt_t               count_q;
	idx_t               walk_q;
	logic               queue_mode_q;

	logic               res_valid_q;
	logic signed [31:0] res_value_q;
	logic               res_has_q;
	stat_t              res_status_q;
	logic               res_last_q;

	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_has_q;
	stat_t              out_status_q;
	logic               out_last_q;

	logic               out_free;
	idx_t               front_dec;
	idx_t               wr_addr;
	idx_t               rd_addr;
	logic [31:0]        wr_data;

	// position k places behind the front, circular
	function automatic idx_t slot(input idx_t base, input idx_t k);
		logic [AW:0] p;
		p = {1'b0, base} + {1'b0, k};
		if (p >= DEPTH_X) p = p - DEPTH_X;
		return p[AW-1:0];
	endfunction

	assign front_dec = (front_q == '0) ? idx_t'(DEPTH - 1) : front_q - idx_t'(1);

	always_comb begin
		case (cmd.wr_sel)
			WR_PUSH: begin
				wr_addr = queue_mode_q ? slot(front_q, count_q[AW-1:0]) : front_dec;
				wr_data = push_value;
			end
			WR_SWAP_A: begin
				wr_addr = front_q;
				wr_data = rd_data_q;
			end
			WR_SWAP_B: begin
				wr_addr = slot(front_q, idx_t'(1));
				wr_data = tmp_q;
			end
			default: begin
				wr_addr = front_q;
				wr_data = push_value;
			end
		endcase
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_FRONT:  rd_addr = front_q;
			RD_SECOND: rd_addr = slot(front_q, idx_t'(1));
			RD_NEXT:   rd_addr = slot(front_q, walk_q + idx_t'(1));
			default:   rd_addr = front_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem_q[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_data_q <= mem_q[rd_addr];
		if (cmd.tmp_ld) tmp_q <= rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q      <= '0;
			count_q      <= '0;
			walk_q       <= '0;
			queue_mode_q <= 1'b0;
		end else begin
			if (cfg_we) queue_mode_q <= cfg_data;
			if (cmd.push_upd) begin
				count_q <= count_q + cnt_t'(1);
				if (!queue_mode_q) front_q <= front_dec;
			end else if (cmd.pop_upd) begin
				count_q <= count_q - cnt_t'(1);
				front_q <= slot(front_q, idx_t'(1));
			end
			if (cmd.walk_clr) begin
				walk_q <= '0;
			end else if (cmd.walk_inc) begin
				walk_q <= walk_q + idx_t'(1);
			end
		end
	end

	// result slot feeds the output register; together they form a skid pair
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.res_ld) begin
				res_valid_q <= 1'b1;
			end else if (out_free) begin
				res_valid_q <= 1'b0;
			end
			if (out_free) out_valid_q <= res_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_value_q  <= cmd.res_mem ? rd_data_q : '0;
			res_has_q    <= cmd.res_mem;
			res_status_q <= cmd.res_status;
			res_last_q   <= cmd.res_last;
		end
		if (out_free && res_valid_q) begin
			out_value_q  <= res_value_q;
			out_has_q    <= res_has_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	assign sts.res_free  = !res_valid_q || out_free;
	assign sts.empty     = (count_q == '0);
	assign sts.lt2       = (count_q < cnt_t'(2));
	assign sts.full      = (count_q == cnt_t'(DEPTH));
	assign sts.walk_last = ((cnt_t'(walk_q) + cnt_t'(1)) == count_q);

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign has_value    = out_has_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

	`SQE_ASSERT_IMP(a_count_range, 1'b1, count_q <= cnt_t'(DEPTH))
	`SQE_ASSERT_IMP(a_push_not_full, cmd.push_upd, !sts.full)
	`SQE_ASSERT_IMP(a_pop_not_empty, cmd.pop_upd, !sts.empty)
	`SQE_ASSERT_IMP(a_res_slot_free, cmd.res_ld, sts.res_free)
	`SQE_ASSERT_IMP(a_walk_in_range, cmd.walk_inc, !sts.walk_last && !sts.empty)
	`SQE_ASSERT_NEXT(a_res_moves, res_valid_q && out_free && !cmd.res_ld, !res_valid_q)

endmodule

### src/stack_queue_engine.sv
// Top level of the stack/queue engine: bounded stack or queue of signed 32-bit values.
// Depends on sqe_pkg, sqe_ctrl and sqe_datapath.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | operation, push_value
//  out     | out_valid/out_stall | result_value, has_value, status, last
//  cfg     | cfg_valid/cfg_ready | cfg_data (queue_mode)
//
// Push, pop, errors and undefined codes: one item per cycle when the output drains.
// Peek reads the front entry and then returns it; swap runs read a, read b, write a,
// write b in turn. Print all: one store read per item, starting from the front.
// Input is stalled while an operation is under way or the result slot is held.
// Reset clears pointers, count, mode, FSM state and valid flags, not the store itself.
module stack_queue_engine
	import sqe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               has_value,
	output logic [2:0]         status,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// mode writes are always taken
	assign cfg_ready = 1'b1;

	sqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sqe_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.push_value   (push_value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.has_value    (has_value),
		.status       (status),
		.last         (last)
	);

endmodule
